>>> design/mbrx_pkg.sv
package mbrx_pkg;

    // CRC-16 as used on the serial bus: reflected polynomial, all-ones start.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function byte that has no length byte and a fixed four byte body.
    localparam logic [7:0] FN_FIXED     = 8'h06;
    localparam logic [8:0] FIXED_LEN    = 9'd4;
    localparam logic [8:0] FIXED_OFFSET = 9'd2;
    localparam logic [8:0] VAR_OFFSET   = 9'd3;
    localparam int         ERR_FUNC_BIT = 7;

    localparam logic [9:0] IDLE_MAX     = 10'd1023;
    localparam logic [9:0] TIMEOUT_RST  = 10'd50;

    // Configuration register indexes.
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_DEV_ADDR_0   = 3'd1;
    localparam logic [2:0] REG_DEV_ADDR_1   = 3'd2;
    localparam logic [2:0] REG_DEV_ADDR_2   = 3'd3;
    localparam logic [2:0] REG_DEV_ADDR_3   = 3'd4;
    localparam logic [2:0] REG_DEV_ENABLE   = 3'd5;

    // Result status codes.
    localparam logic [1:0] RES_GOOD = 2'd0;
    localparam logic [1:0] RES_CRC  = 2'd1;
    localparam logic [1:0] RES_LONG = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CRC,
        ST_RD,
        ST_WR,
        ST_ONE
    } state_t;

    // What the captured item does to the frame.
    typedef enum logic [2:0] {
        ACT_TICK,
        ACT_CRC,
        ACT_HOLD,
        ACT_DROP,
        ACT_ERR_LEN,
        ACT_ERR_CRC,
        ACT_GOOD
    } act_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic crc_shift;
        logic mem_rd;
        logic out_data;
        logic out_one;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic len_zero;
        logic crc_last;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

>>> design/mbrx_ctrl.sv
module mbrx_ctrl
    import mbrx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.exec = 1'b1;
                unique case (sts.act)
                    ACT_CRC:     state_next = ST_CRC;
                    ACT_GOOD:    state_next = sts.len_zero ? ST_ONE : ST_RD;
                    ACT_ERR_LEN: state_next = ST_ONE;
                    ACT_ERR_CRC: state_next = ST_ONE;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_CRC: begin
                cmd.crc_shift = 1'b1;
                if (sts.crc_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (sts.out_free) begin
                    cmd.out_data = 1'b1;
                    state_next   = sts.emit_last ? ST_IDLE : ST_RD;
                end
            end
            ST_ONE: begin
                if (sts.out_free) begin
                    cmd.out_one = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded in the next cycle");

    a_crc_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECODE && sts.act == ACT_CRC) |=> (state_reg == ST_CRC))
        else $error("CRC update did not start after a checked byte");

    a_crc_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC && sts.crc_last) |=> (state_reg == ST_IDLE))
        else $error("CRC update ran past its eighth bit");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_data || cmd.out_one) |-> sts.out_free)
        else $error("result loaded while the output register was still full");
`endif

endmodule

>>> design/mbrx_dp.sv
module mbrx_dp
    import mbrx_pkg::*;
#(
    parameter int MAX_DATA     = 64,
    parameter int DEVICE_SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        s_kind,
    input  logic [7:0]  s_byte,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int FRAME_DEPTH = MAX_DATA + 5;
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(MAX_DATA);

    // Configuration registers.
    logic [9:0] idle_timeout_reg;
    logic [7:0] dev_addr_reg [4];
    logic [3:0] dev_enable_reg;

    // Frame state.
    logic [CW-1:0] byte_count_reg;
    logic [15:0]   crc_reg;
    logic [9:0]    idle_ms_reg;
    logic [7:0]    addr_reg;
    logic [7:0]    func_reg;
    logic [7:0]    len_reg;
    logic [7:0]    crc_lo_reg;
    logic          kind_reg;
    logic [7:0]    rx_reg;
    logic [2:0]    bit_cnt_reg;
    logic [AW-1:0] emit_idx_reg;
    logic [7:0]    rdata_reg;
    logic [1:0]    res_status_reg;
    logic [7:0]    data_mem [MAX_DATA];

    // Output register.
    logic       m_valid_reg;
    logic [1:0] o_status_reg;
    logic [6:0] o_len_reg;
    logic [5:0] o_idx_reg;
    logic [7:0] o_byte_reg;
    logic       o_present_reg;
    logic [3:0] o_match_reg;
    logic       o_last_reg;
    logic [7:0] o_addr_reg;
    logic [7:0] o_func_reg;

    logic [CW+8:0] at_ext;
    logic [8:0]    at9;
    logic          overflow;
    logic          fixed;
    logic          len_byte_now;
    logic [7:0]    len_cur;
    logic [8:0]    cur_len9;
    logic [8:0]    emit_len9;
    logic [8:0]    off9;
    logic [8:0]    end9;
    logic [8:0]    diff9;
    logic          too_long;
    logic          crc_ok;
    logic          data_wr;
    logic [15:0]   crc_shifted;
    logic [9:0]    idle_inc;
    logic [3:0]    match;
    logic [AW+8:0] idx_ext;
    logic [AW+5:0] idx_out_ext;
    logic          out_free;
    act_t          act;

    assign at_ext       = {9'd0, byte_count_reg};
    assign overflow     = byte_count_reg >= CW'(FRAME_DEPTH);
    assign at9          = overflow ? 9'd0 : at_ext[8:0];
    assign fixed        = func_reg == FN_FIXED;
    assign len_byte_now = !fixed && at9 == 9'd2;
    assign len_cur      = len_byte_now ? rx_reg : len_reg;
    assign cur_len9     = fixed ? FIXED_LEN : {1'b0, len_cur};
    assign emit_len9    = fixed ? FIXED_LEN : {1'b0, len_reg};
    assign off9         = fixed ? FIXED_OFFSET : VAR_OFFSET;
    assign end9         = off9 + cur_len9;
    assign diff9        = at9 - off9;
    assign too_long     = len_byte_now && ({1'b0, rx_reg} > 9'(MAX_DATA));
    assign crc_ok       = crc_reg == {rx_reg, crc_lo_reg};
    assign crc_shifted  = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
    assign idle_inc     = (idle_ms_reg == IDLE_MAX) ? idle_ms_reg : idle_ms_reg + 10'd1;
    assign idx_ext      = {9'd0, emit_idx_reg};
    assign idx_out_ext  = {6'd0, emit_idx_reg};
    assign out_free     = !m_valid_reg || m_tready;

    always_comb begin
        priority if (kind_reg) begin
            act = ACT_TICK;
        end else if (at9 == 9'd0) begin
            act = ACT_CRC;
        end else if (at9 == 9'd1) begin
            act = rx_reg[ERR_FUNC_BIT] ? ACT_DROP : ACT_CRC;
        end else if (too_long) begin
            act = ACT_ERR_LEN;
        end else if (at9 < end9) begin
            act = ACT_CRC;
        end else if (at9 == end9) begin
            act = ACT_HOLD;
        end else if (crc_ok) begin
            act = ACT_GOOD;
        end else begin
            act = ACT_ERR_CRC;
        end
    end

    // The address and function header bytes sit below the data offset.
    assign data_wr = cmd.exec && act == ACT_CRC && at9 >= off9;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            match[i] = (i < DEVICE_SLOTS) && dev_enable_reg[i]
                       && dev_addr_reg[i] == addr_reg;
        end
    end

    assign sts.act       = act;
    assign sts.len_zero  = emit_len9 == 9'd0;
    assign sts.crc_last  = bit_cnt_reg == 3'd7;
    assign sts.emit_last = (idx_ext[8:0] + 9'd1) == emit_len9;
    assign sts.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= TIMEOUT_RST;
            for (int i = 0; i < 4; i++) begin
                dev_addr_reg[i] <= 8'd0;
            end
            dev_enable_reg <= 4'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                REG_DEV_ADDR_0:   dev_addr_reg[0] <= cfg_data[7:0];
                REG_DEV_ADDR_1:   dev_addr_reg[1] <= cfg_data[7:0];
                REG_DEV_ADDR_2:   dev_addr_reg[2] <= cfg_data[7:0];
                REG_DEV_ADDR_3:   dev_addr_reg[3] <= cfg_data[7:0];
                REG_DEV_ENABLE:   dev_enable_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            idle_ms_reg    <= 10'd0;
            bit_cnt_reg    <= 3'd0;
            emit_idx_reg   <= '0;
        end else if (cmd.exec) begin
            bit_cnt_reg  <= 3'd0;
            emit_idx_reg <= '0;
            unique case (act)
                ACT_TICK: begin
                    if (idle_inc > idle_timeout_reg) begin
                        byte_count_reg <= '0;
                        crc_reg        <= CRC_INIT;
                        idle_ms_reg    <= 10'd0;
                    end else begin
                        idle_ms_reg <= idle_inc;
                    end
                end
                ACT_CRC: begin
                    byte_count_reg <= CW'(at9 + 9'd1);
                    idle_ms_reg    <= 10'd0;
                    crc_reg        <= ((at9 == 9'd0) ? CRC_INIT : crc_reg) ^ {8'd0, rx_reg};
                end
                ACT_HOLD: begin
                    byte_count_reg <= CW'(at9 + 9'd1);
                    idle_ms_reg    <= 10'd0;
                end
                default: begin
                    byte_count_reg <= '0;
                    crc_reg        <= CRC_INIT;
                end
            endcase
        end else begin
            if (cmd.crc_shift) begin
                crc_reg     <= crc_shifted;
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
            end
            if (cmd.out_data) begin
                emit_idx_reg <= emit_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= s_kind;
            rx_reg   <= s_byte;
        end
        if (cmd.exec) begin
            if (act == ACT_CRC && at9 == 9'd0) begin
                addr_reg <= rx_reg;
            end
            if (act == ACT_CRC && at9 == 9'd1) begin
                func_reg <= rx_reg;
            end
            if ((act == ACT_CRC || act == ACT_ERR_LEN) && len_byte_now) begin
                len_reg <= rx_reg;
            end
            if (act == ACT_HOLD) begin
                crc_lo_reg <= rx_reg;
            end
            if (act == ACT_ERR_LEN) begin
                res_status_reg <= RES_LONG;
            end else if (act == ACT_ERR_CRC) begin
                res_status_reg <= RES_CRC;
            end else begin
                res_status_reg <= RES_GOOD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (data_wr) begin
            data_mem[diff9[AW-1:0]] <= rx_reg;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= data_mem[emit_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_data || cmd.out_one) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_data || cmd.out_one) begin
            o_addr_reg <= addr_reg;
            o_func_reg <= func_reg;
            o_len_reg  <= emit_len9[6:0];
        end
        if (cmd.out_data) begin
            o_status_reg  <= RES_GOOD;
            o_idx_reg     <= idx_out_ext[5:0];
            o_byte_reg    <= rdata_reg;
            o_present_reg <= 1'b1;
            o_match_reg   <= match;
            o_last_reg    <= sts.emit_last;
        end else if (cmd.out_one) begin
            o_status_reg  <= res_status_reg;
            o_idx_reg     <= 6'd0;
            o_byte_reg    <= 8'd0;
            o_present_reg <= 1'b0;
            o_match_reg   <= (res_status_reg == RES_GOOD) ? match : 4'd0;
            o_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_match_reg, o_byte_reg, o_idx_reg, o_len_reg,
                       o_func_reg, o_addr_reg};
    assign m_tuser  = {o_present_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

endmodule

>>> design/modbus_rtu_frame_receiver.sv
// Channel | Direction | Handshake            | Payload
// s_      | in        | s_tvalid / s_tready  | tdata: rx_byte; tuser: func (1 = ms tick)
// m_      | out       | m_tvalid / m_tready  | tdata: header, index, byte, match; tuser; tlast
// cfg_    | in        | cfg_valid / cfg_ready| cfg_index selects register, cfg_data value
//
// A tick passes from idle through decode; a byte that enters the CRC then goes through the
// bit-serial CRC unit that handles one bit per cycle; a byte only stored or dropped ends at
// decode. A byte that ends a frame with a single item waits for a free output register; a
// good frame with data emits one item per registered data buffer read, each held on a stall.
// Reset (aresetn low at a clock edge) empties the frame and restores register defaults.
// A stalled output holds its item; the next input is taken once the current one is done.
module modbus_rtu_frame_receiver
    import mbrx_pkg::*;
#(
    parameter int MAX_DATA     = 64,
    parameter int DEVICE_SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_address, [15:8] function_code, [22:16] data_length,
    // [28:23] data_index, [36:29] data_byte, [40:37] device_match, rest zero
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,   // [1:0] status, [2] data_present
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    mbrx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbrx_dp #(
        .MAX_DATA     (MAX_DATA),
        .DEVICE_SLOTS (DEVICE_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_kind    (s_tuser[0]),
        .s_byte    (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
